@@ hdl/udpf_pkg.sv @@
// Package for the UDP/IPv4 frame filter: sizes, header offsets, protocol constants
// and the structs passed between the filter's modules.
// Depends on nothing; used by the filter modules, the top level and the testbench.
package udpf_pkg;

    // Largest frame in bytes; longer frames are rejected.
    localparam int FRAME_BYTES_MAX = 2048;

    // Byte position counter saturates at FRAME_BYTES_MAX, so it must hold that value.
    localparam int POS_W   = $clog2(FRAME_BYTES_MAX + 1);
    // Width for position and header offset compares, one bit above the counter.
    localparam int CMP_W   = POS_W + 1;
    // Width for payload window bounds: header end plus a 16-bit length.
    localparam int RANGE_W = 17;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WANTED_PORT = 2'd0,
        CFG_PAYLOAD_CAP = 2'd1
    } cfg_index_t;

    localparam logic [15:0] PAYLOAD_CAP_RESET = 16'd2048;
    localparam logic [15:0] WANTED_PORT_RESET = 16'd0;

    // Protocol constants.
    localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
    localparam logic [7:0]  PROTO_UDP       = 8'd17;
    localparam logic [3:0]  IP_VERSION_4    = 4'd4;
    localparam logic [3:0]  IHL_MIN         = 4'd5;
    localparam logic [7:0]  ETH_HDR_BYTES   = 8'd14;
    localparam logic [7:0]  UDP_HDR_BYTES   = 8'd8;
    localparam logic [7:0]  MIN_FRAME_BYTES = 8'd42;

    // Fixed byte offsets of Ethernet and IPv4 header fields within the frame.
    localparam logic [POS_W-1:0] POS_ETHERTYPE_HI = POS_W'(12);
    localparam logic [POS_W-1:0] POS_ETHERTYPE_LO = POS_W'(13);
    localparam logic [POS_W-1:0] POS_VER_IHL      = POS_W'(14);
    localparam logic [POS_W-1:0] POS_TOTLEN_HI    = POS_W'(16);
    localparam logic [POS_W-1:0] POS_TOTLEN_LO    = POS_W'(17);
    localparam logic [POS_W-1:0] POS_PROTOCOL     = POS_W'(23);
    localparam logic [POS_W-1:0] POS_SRC_ADDR_LO  = POS_W'(26);
    localparam logic [POS_W-1:0] POS_SRC_ADDR_HI  = POS_W'(29);

    // Offsets of UDP header fields from the start of the UDP header.
    localparam logic [7:0] UDP_SPORT_HI = 8'd0;
    localparam logic [7:0] UDP_SPORT_LO = 8'd1;
    localparam logic [7:0] UDP_DPORT_HI = 8'd2;
    localparam logic [7:0] UDP_DPORT_LO = 8'd3;
    localparam logic [7:0] UDP_LEN_HI   = 8'd4;
    localparam logic [7:0] UDP_LEN_LO   = 8'd5;

    // Configuration values seen by the parser.
    typedef struct packed {
        logic [15:0] wanted_port;
        logic [15:0] payload_cap;
    } udpf_cfg_t;

    // One result item.
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        verdict_valid;
        logic        accepted;
        logic [31:0] source_address;
        logic [15:0] source_port;
        logic [15:0] payload_length;
    } udpf_result_t;

endpackage

@@ hdl/udpf_if.sv @@
// Stream interfaces of the UDP/IPv4 frame filter: frame bytes in, results out.
// Valid/ready handshake; a transfer happens when both are high at a clock edge.
// Depends on nothing.
interface udpf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, frame_byte, last_byte, input ready);
    modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

interface udpf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        verdict_valid;
    logic        accepted;
    logic [31:0] source_address;
    logic [15:0] source_port;
    logic [15:0] payload_length;

    modport source (output valid, payload_byte, payload_valid, verdict_valid, accepted,
                    source_address, source_port, payload_length, input ready);
    modport sink   (input valid, payload_byte, payload_valid, verdict_valid, accepted,
                    source_address, source_port, payload_length, output ready);
endinterface

@@ hdl/udpf_cfg_regs.sv @@
// Configuration registers of the UDP/IPv4 frame filter (wanted port, payload cap).
// Depends on udpf_pkg.
module udpf_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [udpf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [udpf_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    output udpf_pkg::udpf_cfg_t             cfg
);

    logic [15:0] wanted_port_reg;
    logic [15:0] payload_cap_reg;

    // Register writes; an index beyond the register list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_port_reg <= udpf_pkg::WANTED_PORT_RESET;
            payload_cap_reg <= udpf_pkg::PAYLOAD_CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                udpf_pkg::CFG_WANTED_PORT: wanted_port_reg <= cfg_wr_data[15:0];
                udpf_pkg::CFG_PAYLOAD_CAP: payload_cap_reg <= cfg_wr_data[15:0];
                default: ;
            endcase
        end
    end

    assign cfg.wanted_port = wanted_port_reg;
    assign cfg.payload_cap = payload_cap_reg;

endmodule

@@ hdl/udpf_hdr_parse.sv @@
// Header parser of the UDP/IPv4 frame filter: per-frame state registers and the
// single-pass logic that turns one frame byte into one result item.
// Depends on udpf_pkg.
module udpf_hdr_parse (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   take,
    input  logic [7:0]             frame_byte,
    input  logic                   last_byte,
    input  udpf_pkg::udpf_cfg_t    cfg,
    output udpf_pkg::udpf_result_t result
);

    localparam int POS_W   = udpf_pkg::POS_W;
    localparam int CMP_W   = udpf_pkg::CMP_W;
    localparam int RANGE_W = udpf_pkg::RANGE_W;

    // Per-frame state.
    logic [POS_W-1:0] pos_reg,   pos_next;
    logic [5:0]       hl_reg,    hl_next;
    logic [15:0]      iptl_reg,  iptl_next;
    logic [15:0]      udpl_reg,  udpl_next;
    logic [31:0]      saddr_reg, saddr_next;
    logic [15:0]      sport_reg, sport_next;
    logic [7:0]       shift_reg, shift_next;
    logic             rej_reg,   rej_next;

    // Values after this byte's field captures and checks.
    logic [5:0]         hl_now;
    logic [15:0]        iptl_now;
    logic [15:0]        udpl_now;
    logic [31:0]        saddr_now;
    logic [15:0]        sport_now;
    logic [7:0]         shift_now;
    logic               rej_now;
    logic [7:0]         udp_start;
    logic [CMP_W-1:0]   pos_x;
    logic [CMP_W-1:0]   udp_x;
    logic [15:0]        hl_ext;
    logic [15:0]        body;
    logic [RANGE_W-1:0] pay_lo;
    logic [RANGE_W-1:0] pay_hi;
    logic [RANGE_W-1:0] pos_r;
    logic [CMP_W-1:0]   count;
    logic               pvalid;
    logic               ok;

    // Field capture and checks for the current byte.
    always_comb
    begin
        hl_now    = hl_reg;
        iptl_now  = iptl_reg;
        udpl_now  = udpl_reg;
        saddr_now = saddr_reg;
        sport_now = sport_reg;
        shift_now = shift_reg;
        rej_now   = rej_reg || (pos_reg >= POS_W'(udpf_pkg::FRAME_BYTES_MAX));

        // Ethernet and IPv4 fields at fixed offsets.
        if (pos_reg == udpf_pkg::POS_ETHERTYPE_HI)
        begin
            shift_now = frame_byte;
        end
        else if (pos_reg == udpf_pkg::POS_ETHERTYPE_LO)
        begin
            if ({shift_reg, frame_byte} != udpf_pkg::ETHERTYPE_IPV4)
                rej_now = 1'b1;
        end
        else if (pos_reg == udpf_pkg::POS_VER_IHL)
        begin
            if (frame_byte[7:4] != udpf_pkg::IP_VERSION_4 ||
                frame_byte[3:0] < udpf_pkg::IHL_MIN)
                rej_now = 1'b1;
            hl_now = {frame_byte[3:0], 2'b00};
        end
        else if (pos_reg == udpf_pkg::POS_TOTLEN_HI)
        begin
            iptl_now = {frame_byte, 8'h00};
        end
        else if (pos_reg == udpf_pkg::POS_TOTLEN_LO)
        begin
            iptl_now = iptl_reg | {8'h00, frame_byte};
            if (iptl_now < {10'd0, hl_now} + 16'(udpf_pkg::UDP_HDR_BYTES))
                rej_now = 1'b1;
        end
        else if (pos_reg == udpf_pkg::POS_PROTOCOL)
        begin
            if (frame_byte != udpf_pkg::PROTO_UDP)
                rej_now = 1'b1;
        end
        else if (pos_reg >= udpf_pkg::POS_SRC_ADDR_LO && pos_reg <= udpf_pkg::POS_SRC_ADDR_HI)
        begin
            saddr_now = {saddr_reg[23:0], frame_byte};
        end

        // UDP fields, placed after the IPv4 header of the stored length.
        udp_start = udpf_pkg::ETH_HDR_BYTES + {2'b00, hl_now};
        pos_x     = CMP_W'(pos_reg);
        udp_x     = CMP_W'(udp_start);
        hl_ext    = {10'd0, hl_now};

        if (pos_x == udp_x + CMP_W'(udpf_pkg::UDP_SPORT_HI))
        begin
            sport_now = {frame_byte, 8'h00};
        end
        else if (pos_x == udp_x + CMP_W'(udpf_pkg::UDP_SPORT_LO))
        begin
            sport_now = sport_reg | {8'h00, frame_byte};
        end
        else if (pos_x == udp_x + CMP_W'(udpf_pkg::UDP_DPORT_HI))
        begin
            shift_now = frame_byte;
        end
        else if (pos_x == udp_x + CMP_W'(udpf_pkg::UDP_DPORT_LO))
        begin
            if ({shift_reg, frame_byte} != cfg.wanted_port)
                rej_now = 1'b1;
        end
        else if (pos_x == udp_x + CMP_W'(udpf_pkg::UDP_LEN_HI))
        begin
            udpl_now = {frame_byte, 8'h00};
        end
        else if (pos_x == udp_x + CMP_W'(udpf_pkg::UDP_LEN_LO))
        begin
            udpl_now = udpl_reg | {8'h00, frame_byte};
            if (udpl_now < 16'(udpf_pkg::UDP_HDR_BYTES))
                rej_now = 1'b1;
            else if (iptl_now < hl_ext || udpl_now > iptl_now - hl_ext)
                rej_now = 1'b1;
            else if (udpl_now - 16'(udpf_pkg::UDP_HDR_BYTES) > cfg.payload_cap)
                rej_now = 1'b1;
        end

        // Payload window and tentative payload marking.
        body   = (udpl_now >= 16'(udpf_pkg::UDP_HDR_BYTES)) ?
                 udpl_now - 16'(udpf_pkg::UDP_HDR_BYTES) : 16'd0;
        pay_lo = RANGE_W'(udp_start) + RANGE_W'(udpf_pkg::UDP_HDR_BYTES);
        pay_hi = pay_lo + RANGE_W'(body);
        pos_r  = RANGE_W'(pos_reg);
        pvalid = !rej_now && pos_r >= pay_lo && pos_r < pay_hi;

        // Frame length checks for the verdict on the last byte.
        count = pos_x + CMP_W'(1);
        ok    = !rej_now
                && count >= CMP_W'(udpf_pkg::MIN_FRAME_BYTES)
                && udp_x + CMP_W'(udpf_pkg::UDP_HDR_BYTES) <= count
                && RANGE_W'(udpf_pkg::ETH_HDR_BYTES) + RANGE_W'(iptl_now)
                   <= RANGE_W'(count);

        result.payload_byte   = pvalid ? frame_byte : 8'd0;
        result.payload_valid  = pvalid;
        result.verdict_valid  = last_byte;
        result.accepted       = last_byte && ok;
        result.source_address = (last_byte && ok) ? saddr_now : 32'd0;
        result.source_port    = (last_byte && ok) ? sport_now : 16'd0;
        result.payload_length = (last_byte && ok) ? body : 16'd0;

        // State for the next byte; the last byte starts a fresh frame.
        if (last_byte)
        begin
            pos_next   = '0;
            hl_next    = '0;
            iptl_next  = '0;
            udpl_next  = '0;
            saddr_next = '0;
            sport_next = '0;
            shift_next = '0;
            rej_next   = 1'b0;
        end
        else
        begin
            pos_next   = (pos_reg < POS_W'(udpf_pkg::FRAME_BYTES_MAX)) ?
                         pos_reg + POS_W'(1) : POS_W'(udpf_pkg::FRAME_BYTES_MAX);
            hl_next    = hl_now;
            iptl_next  = iptl_now;
            udpl_next  = udpl_now;
            saddr_next = saddr_now;
            sport_next = sport_now;
            shift_next = shift_now;
            rej_next   = rej_now;
        end
    end

    // Frame state advances on each input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            hl_reg    <= '0;
            iptl_reg  <= '0;
            udpl_reg  <= '0;
            saddr_reg <= '0;
            sport_reg <= '0;
            shift_reg <= '0;
            rej_reg   <= 1'b0;
        end
        else if (take)
        begin
            pos_reg   <= pos_next;
            hl_reg    <= hl_next;
            iptl_reg  <= iptl_next;
            udpl_reg  <= udpl_next;
            saddr_reg <= saddr_next;
            sport_reg <= sport_next;
            shift_reg <= shift_next;
            rej_reg   <= rej_next;
        end
    end

endmodule

@@ hdl/udpf_out_buf.sv @@
// Two-entry result buffer of the UDP/IPv4 frame filter; it decouples the input
// side from a stalled receiver. Depends on udpf_pkg and udpf_out_if.
module udpf_out_buf (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  udpf_pkg::udpf_result_t push_data,
    output logic                   has_room,
    udpf_out_if.source             result_out
);

    udpf_pkg::udpf_result_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       pop;

    assign has_room = (count_reg != 2'd2);
    assign pop      = result_out.valid && result_out.ready;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    // Head entry drives the output channel.
    assign result_out.valid          = (count_reg != 2'd0);
    assign result_out.payload_byte   = entry_reg[rd_ptr_reg].payload_byte;
    assign result_out.payload_valid  = entry_reg[rd_ptr_reg].payload_valid;
    assign result_out.verdict_valid  = entry_reg[rd_ptr_reg].verdict_valid;
    assign result_out.accepted       = entry_reg[rd_ptr_reg].accepted;
    assign result_out.source_address = entry_reg[rd_ptr_reg].source_address;
    assign result_out.source_port    = entry_reg[rd_ptr_reg].source_port;
    assign result_out.payload_length = entry_reg[rd_ptr_reg].payload_length;

endmodule

@@ hdl/udp_ipv4_frame_filter_core.sv @@
// Top level of the UDP/IPv4 frame filter.
// Depends on udpf_pkg, udpf_if, udpf_cfg_regs, udpf_hdr_parse and udpf_out_buf.
//
// Usage:
//   frame_in carries one Ethernet frame byte per transfer (FCS removed), with
//   last_byte high on the final byte of each frame. result_out returns exactly
//   one result per input byte, in order. Payload bytes of a UDP datagram are
//   marked with payload_valid as they pass; the result for the last byte has
//   verdict_valid high and, when all checks passed, accepted high together with
//   the source address, source port and payload length. On a reject the
//   receiver drops the payload bytes it was given for that frame.
//   Throughput is one byte per cycle while the result buffer has room; each
//   result is registered in a buffer entry before it appears on result_out.
//   A two-entry result buffer lets the block take a byte while a result waits;
//   frame_in.ready falls only when both entries are held by a stalled receiver.
//   Reset clears the frame state and the buffer and loads wanted_port = 0 and
//   payload_cap = 2048. Configuration is written through cfg_wr_en, cfg_index
//   and cfg_wr_data while no frame is in flight.
module udp_ipv4_frame_filter_core (
    input  logic                             clk,
    input  logic                             rst_n,
    udpf_in_if.sink                          frame_in,
    udpf_out_if.source                       result_out,
    input  logic                             cfg_wr_en,
    input  logic [udpf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [udpf_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);

    udpf_pkg::udpf_cfg_t    cfg;
    udpf_pkg::udpf_result_t result;
    logic                   has_room;
    logic                   take;

    // Input transfer when the buffer has room.
    assign frame_in.ready = has_room;
    assign take           = frame_in.valid && has_room;

    udpf_cfg_regs u_cfg_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    udpf_hdr_parse u_hdr_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .frame_byte (frame_in.frame_byte),
        .last_byte  (frame_in.last_byte),
        .cfg        (cfg),
        .result     (result)
    );

    udpf_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (take),
        .push_data  (result),
        .has_room   (has_room),
        .result_out (result_out)
    );

endmodule

@@ hdl/udpf_checker.sv @@
// Port-level checker for the UDP/IPv4 frame filter, bound to the top level.
// Depends on udp_ipv4_frame_filter_core and its interface ports.
module udpf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  payload_byte,
    input logic        payload_valid,
    input logic        verdict_valid,
    input logic        accepted,
    input logic [31:0] source_address,
    input logic [15:0] source_port,
    input logic [15:0] payload_length
);

    logic [2:0] pending_reg;
    logic [2:0] pending_next;

    // Results owed: input transfers not yet matched by output transfers.
    always_comb
    begin
        pending_next = pending_reg + {2'b00, in_valid && in_ready}
                       - {2'b00, out_valid && out_ready};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= 3'd0;
        else
            pending_reg <= pending_next;
    end

    // A stalled result stays offered.
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    // A stalled result keeps its contents.
    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable({payload_byte, payload_valid, verdict_valid,
            accepted, source_address, source_port, payload_length}))
        else $error("result changed while stalled");

    // Every result shown belongs to an earlier input transfer.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("result without a matching input transfer");

    // The block never holds more results than its buffer.
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 3'd2 |-> !in_ready)
        else $error("input accepted with a full result buffer");

    // Header fields are reported only with an accept verdict.
    a_fields_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> source_address == 32'd0 && source_port == 16'd0
            && payload_length == 16'd0)
        else $error("header fields reported without an accept verdict");

endmodule

bind udp_ipv4_frame_filter_core udpf_checker u_udpf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (frame_in.valid),
    .in_ready       (frame_in.ready),
    .out_valid      (result_out.valid),
    .out_ready      (result_out.ready),
    .payload_byte   (result_out.payload_byte),
    .payload_valid  (result_out.payload_valid),
    .verdict_valid  (result_out.verdict_valid),
    .accepted       (result_out.accepted),
    .source_address (result_out.source_address),
    .source_port    (result_out.source_port),
    .payload_length (result_out.payload_length)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for udp_ipv4_frame_filter_core: streams Ethernet frames
// byte by byte, predicts every result in step and compares each output transfer.
// Depends on udpf_pkg, the udpf_in_if/udpf_out_if interfaces and the filter RTL.
module tb;
    import udpf_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int PRINT_LIMIT     = 40;
    localparam int PHASE_BYTES     = 200;
    localparam int UDP_AT_MIN_IHL  = ETH_HDR_BYTES + 4 * IHL_MIN;

    // Register indexes the block does not decode.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_3 = 2'd3;

    // Ways a well-formed frame is broken.
    typedef enum int unsigned {
        FAULT_ETHERTYPE,
        FAULT_VERSION,
        FAULT_IHL,
        FAULT_PROTOCOL,
        FAULT_TOTAL_LEN,
        FAULT_UDP_LEN,
        FAULT_DPORT,
        FAULT_TRUNCATE,
        FAULT_LONG_CLAIM,
        FAULT_CORRUPT,
        FAULT_COUNT
    } frame_fault_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } rx_byte_t;

    logic clk;
    logic rst_n = 1'b0;

    // Stimulus-side registers, known from time zero.
    logic                   in_valid    = 1'b0;
    logic [7:0]             in_byte     = 8'h00;
    logic                   in_last     = 1'b0;
    logic                   out_ready   = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;

    udpf_in_if  frame_in();
    udpf_out_if result_out();

    assign frame_in.valid      = in_valid;
    assign frame_in.frame_byte = in_byte;
    assign frame_in.last_byte  = in_last;
    assign result_out.ready    = out_ready;

    udp_ipv4_frame_filter_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_in    (frame_in),
        .result_out  (result_out),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    // Configuration as the filter should currently see it.
    logic [15:0] cfg_wanted_port = WANTED_PORT_RESET;
    logic [15:0] cfg_payload_cap = PAYLOAD_CAP_RESET;

    // Per-frame parser state of the predictor.
    logic [11:0] frm_pos       = '0;
    logic [5:0]  frm_hdr_len   = '0;
    logic [15:0] frm_total_len = '0;
    logic [15:0] frm_udp_len   = '0;
    logic [31:0] frm_src_addr  = '0;
    logic [15:0] frm_src_port  = '0;
    logic [7:0]  frm_shift     = '0;
    logic        frm_rejected  = 1'b0;

    rx_byte_t     pending_bytes[$];
    udpf_result_t expected_results[$];
    logic [7:0]   frame_buf[$];
    rx_byte_t     next_byte;
    udpf_result_t oldest_result;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int results_seen   = 0;
    int cycle_count    = 0;

    // 2 ns clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Works out the result the filter produces for one frame byte and advances the
    // parser state exactly as the hardware should.
    function automatic udpf_result_t predict_filter_result(input logic [7:0] b,
                                                           input logic last);
        udpf_result_t r;
        int unsigned  pos;
        int unsigned  hl;
        int unsigned  u;
        int unsigned  ulen;
        int unsigned  tlen;
        int unsigned  body;
        int unsigned  count;
        logic         ok;

        r   = '0;
        pos = frm_pos;
        hl  = frm_hdr_len;

        // Anything at or past the size limit spoils the frame.
        if (pos >= FRAME_BYTES_MAX)
            frm_rejected = 1'b1;

        // Ethernet and IPv4 fields at fixed offsets.
        if (pos == POS_ETHERTYPE_HI)
            frm_shift = b;
        else if (pos == POS_ETHERTYPE_LO)
        begin
            if ({frm_shift, b} != ETHERTYPE_IPV4)
                frm_rejected = 1'b1;
        end
        else if (pos == POS_VER_IHL)
        begin
            if (b[7:4] != IP_VERSION_4 || b[3:0] < IHL_MIN)
                frm_rejected = 1'b1;
            hl          = 4 * b[3:0];
            frm_hdr_len = 6'(hl);
        end
        else if (pos == POS_TOTLEN_HI)
            frm_total_len = {b, 8'h00};
        else if (pos == POS_TOTLEN_LO)
        begin
            frm_total_len = frm_total_len | {8'h00, b};
            if (frm_total_len < hl + UDP_HDR_BYTES)
                frm_rejected = 1'b1;
        end
        else if (pos == POS_PROTOCOL)
        begin
            if (b != PROTO_UDP)
                frm_rejected = 1'b1;
        end
        else if (pos >= POS_SRC_ADDR_LO && pos <= POS_SRC_ADDR_HI)
            frm_src_addr = {frm_src_addr[23:0], b};

        // UDP header fields follow the IP header, wherever its length puts them.
        u = ETH_HDR_BYTES + hl;
        if (pos == u + UDP_SPORT_HI)
            frm_src_port = {b, 8'h00};
        else if (pos == u + UDP_SPORT_LO)
            frm_src_port = frm_src_port | {8'h00, b};
        else if (pos == u + UDP_DPORT_HI)
            frm_shift = b;
        else if (pos == u + UDP_DPORT_LO)
        begin
            if ({frm_shift, b} != cfg_wanted_port)
                frm_rejected = 1'b1;
        end
        else if (pos == u + UDP_LEN_HI)
            frm_udp_len = {b, 8'h00};
        else if (pos == u + UDP_LEN_LO)
        begin
            frm_udp_len = frm_udp_len | {8'h00, b};
            ulen        = frm_udp_len;
            tlen        = frm_total_len;
            if (ulen < UDP_HDR_BYTES)
                frm_rejected = 1'b1;
            else if (tlen < hl || ulen > tlen - hl)
                frm_rejected = 1'b1;
            else if (ulen - UDP_HDR_BYTES > cfg_payload_cap)
                frm_rejected = 1'b1;
        end

        // Payload bytes pass tentatively while nothing has failed.
        ulen = frm_udp_len;
        tlen = frm_total_len;
        body = (ulen >= UDP_HDR_BYTES) ? ulen - UDP_HDR_BYTES : 0;
        if (!frm_rejected && pos >= u + UDP_HDR_BYTES && pos < u + UDP_HDR_BYTES + body)
        begin
            r.payload_byte  = b;
            r.payload_valid = 1'b1;
        end

        // Verdict and length checks on the final byte, then a fresh frame.
        if (last)
        begin
            count = pos + 1;
            ok    = !frm_rejected;
            if (count < MIN_FRAME_BYTES)
                ok = 1'b0;
            if (u + UDP_HDR_BYTES > count)
                ok = 1'b0;
            if (ETH_HDR_BYTES + tlen > count)
                ok = 1'b0;
            r.verdict_valid = 1'b1;
            if (ok)
            begin
                r.accepted       = 1'b1;
                r.source_address = frm_src_addr;
                r.source_port    = frm_src_port;
                r.payload_length = 16'(body);
            end
            frm_pos       = '0;
            frm_hdr_len   = '0;
            frm_total_len = '0;
            frm_udp_len   = '0;
            frm_src_addr  = '0;
            frm_src_port  = '0;
            frm_shift     = '0;
            frm_rejected  = 1'b0;
        end
        else
            frm_pos = (pos < FRAME_BYTES_MAX) ? 12'(pos + 1) : 12'(FRAME_BYTES_MAX);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("[%0t] mismatch at result %0d: %s", $time, results_seen, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, predicted %0h", name, got, want));
    endtask

    // Frame byte driver: a new byte is offered once the previous one has transferred.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_byte  <= 8'h00;
            in_last  <= 1'b0;
        end
        else
        begin
            if (in_valid && frame_in.ready)
                expected_results.push_back(predict_filter_result(in_byte, in_last));
            if (!in_valid || frame_in.ready)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_byte = pending_bytes.pop_front();
                    in_valid <= 1'b1;
                    in_byte  <= next_byte.data;
                    in_last  <= next_byte.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: each result transfer is checked against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (result_out.valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result arrived with nothing predicted");
                else
                begin
                    oldest_result = expected_results.pop_front();
                    check_field("payload_byte", result_out.payload_byte,
                                oldest_result.payload_byte);
                    check_field("payload_valid", result_out.payload_valid,
                                oldest_result.payload_valid);
                    check_field("verdict_valid", result_out.verdict_valid,
                                oldest_result.verdict_valid);
                    check_field("accepted", result_out.accepted, oldest_result.accepted);
                    check_field("source_address", result_out.source_address,
                                oldest_result.source_address);
                    check_field("source_port", result_out.source_port,
                                oldest_result.source_port);
                    check_field("payload_length", result_out.payload_length,
                                oldest_result.payload_length);
                end
                results_seen++;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[%0t] timeout after %0d cycles", $time, cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_WANTED_PORT: cfg_wanted_port = val;
            CFG_PAYLOAD_CAP: cfg_payload_cap = val;
            default: ;
        endcase
    endtask

    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    task automatic set_word(input int at, input logic [15:0] w);
        frame_buf[at]     = w[15:8];
        frame_buf[at + 1] = w[7:0];
    endtask

    // Well-formed UDP/IPv4 frame with random addresses, options and payload.
    task automatic build_frame(input int ihl, input logic [15:0] dport,
                               input int payload_n, input int pad_n);
        int hl;
        int u;
        int i;

        hl = 4 * ihl;
        u  = ETH_HDR_BYTES + hl;
        frame_buf.delete();
        for (i = 0; i < u + UDP_HDR_BYTES + payload_n + pad_n; i++)
            frame_buf.push_back(8'($urandom));
        while (frame_buf.size() < MIN_FRAME_BYTES)
            frame_buf.push_back(8'($urandom));
        set_word(POS_ETHERTYPE_HI, ETHERTYPE_IPV4);
        frame_buf[POS_VER_IHL]  = {IP_VERSION_4, 4'(ihl)};
        set_word(POS_TOTLEN_HI, 16'(hl + UDP_HDR_BYTES + payload_n));
        frame_buf[POS_PROTOCOL] = PROTO_UDP;
        set_word(u + UDP_DPORT_HI, dport);
        set_word(u + UDP_LEN_HI, 16'(UDP_HDR_BYTES + payload_n));
    endtask

    // Breaks one check of the frame in frame_buf.
    task automatic apply_fault(input frame_fault_t fault, input int ihl);
        int u;
        int at;

        u = ETH_HDR_BYTES + 4 * ihl;
        case (fault)
            FAULT_ETHERTYPE:
            begin
                at            = POS_ETHERTYPE_HI + $urandom_range(1);
                frame_buf[at] = frame_buf[at] ^ 8'($urandom_range(255, 1));
            end
            FAULT_VERSION:
                frame_buf[POS_VER_IHL] = {4'(IP_VERSION_4 + $urandom_range(15, 1)), 4'(ihl)};
            FAULT_IHL:
                frame_buf[POS_VER_IHL] = {IP_VERSION_4, 4'($urandom_range(IHL_MIN - 1))};
            FAULT_PROTOCOL:
                frame_buf[POS_PROTOCOL] = PROTO_UDP ^ 8'($urandom_range(255, 1));
            FAULT_TOTAL_LEN:
                set_word(POS_TOTLEN_HI, 16'($urandom));
            FAULT_UDP_LEN:
                set_word(u + UDP_LEN_HI, ($urandom_range(1) == 0) ?
                         16'($urandom_range(UDP_HDR_BYTES - 1)) : 16'($urandom));
            FAULT_DPORT:
                set_word(u + UDP_DPORT_HI, 16'($urandom));
            FAULT_TRUNCATE:
            begin
                at = $urandom_range(frame_buf.size() - 1, 1);
                while (frame_buf.size() > at)
                    void'(frame_buf.pop_back());
            end
            FAULT_LONG_CLAIM:
                // Header claims more bytes than the frame carries.
                set_word(POS_TOTLEN_HI,
                         16'(frame_buf.size() - ETH_HDR_BYTES + $urandom_range(40, 1)));
            default:
            begin
                at            = $urandom_range(frame_buf.size() - 1);
                frame_buf[at] = 8'($urandom);
            end
        endcase
    endtask

    // Queues frame_buf[from..upto-1]; the frame's final byte carries the last flag.
    task automatic send_bytes(input int from, input int upto);
        rx_byte_t item;
        int       i;

        for (i = from; i < upto; i++)
        begin
            item.data = frame_buf[i];
            item.last = (i == frame_buf.size() - 1);
            pending_bytes.push_back(item);
        end
    endtask

    // Mostly well-formed frames for the current port, some broken, some pure noise.
    task automatic random_traffic(input int budget);
        int sent;
        int ihl;
        int n;
        int style;

        sent = 0;
        while (sent < budget)
        begin
            ihl = ($urandom_range(4) == 0) ? $urandom_range(15, IHL_MIN + 1) : IHL_MIN;
            n   = ($urandom_range(9) == 0) ? $urandom_range(200, 17) : $urandom_range(16);
            build_frame(ihl, cfg_wanted_port, n,
                        ($urandom_range(3) == 0) ? $urandom_range(12, 1) : 0);
            style = $urandom_range(9);
            if (style == 0)
            begin
                frame_buf.delete();
                repeat ($urandom_range(80, 1))
                    frame_buf.push_back(8'($urandom));
            end
            else if (style <= 3)
                apply_fault(frame_fault_t'($urandom_range(FAULT_COUNT - 1)), ihl);
            send_bytes(0, frame_buf.size());
            sent += frame_buf.size();
        end
    endtask

    // Test sequence.
    initial
    begin
        int f;
        int ph;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset configuration: port 0 wanted, cap 2048.
        build_frame(IHL_MIN, cfg_wanted_port, 0, 0);
        send_bytes(0, frame_buf.size());

        // Sender holds off mid-frame until every result is back.
        build_frame(IHL_MIN, cfg_wanted_port, 12, 0);
        send_bytes(0, 20);
        wait_for_drain();
        send_bytes(20, frame_buf.size());

        // Longest IP header, with options.
        build_frame(15, cfg_wanted_port, 3, 5);
        send_bytes(0, frame_buf.size());

        // One frame for each way a check can fail.
        for (f = 0; f < FAULT_COUNT; f++)
        begin
            build_frame(IHL_MIN, cfg_wanted_port, 6, 0);
            apply_fault(frame_fault_t'(f), IHL_MIN);
            send_bytes(0, frame_buf.size());
        end

        // Single-byte frame.
        frame_buf.delete();
        frame_buf.push_back(8'($urandom));
        send_bytes(0, 1);
        wait_for_drain();

        // Top port and largest cap.
        write_reg(CFG_WANTED_PORT, 16'hFFFF);
        write_reg(CFG_PAYLOAD_CAP, 16'hFFFF);
        build_frame(IHL_MIN, cfg_wanted_port, 10, 0);
        send_bytes(0, frame_buf.size());
        build_frame(IHL_MIN, cfg_wanted_port, 10, 0);
        set_word(POS_TOTLEN_HI, 16'hFFFF);
        set_word(UDP_AT_MIN_IHL + UDP_LEN_HI, 16'hFFFF);
        send_bytes(0, frame_buf.size());
        // Huge claimed payload passes the header checks, then fails on frame length.
        build_frame(IHL_MIN, cfg_wanted_port, 10, 0);
        set_word(POS_TOTLEN_HI, 16'hFFFF);
        set_word(UDP_AT_MIN_IHL + UDP_LEN_HI, 16'hFFFF - 4 * IHL_MIN);
        send_bytes(0, frame_buf.size());
        wait_for_drain();

        // Zero cap: only an empty payload passes.
        write_reg(CFG_PAYLOAD_CAP, 16'h0000);
        build_frame(IHL_MIN, cfg_wanted_port, 0, 3);
        send_bytes(0, frame_buf.size());
        build_frame(IHL_MIN, cfg_wanted_port, 1, 0);
        send_bytes(0, frame_buf.size());
        wait_for_drain();

        // Writes to undecoded indexes change nothing.
        write_reg(CFG_UNUSED_2, 16'hFFFF);
        write_reg(CFG_UNUSED_3, 16'h0000);
        build_frame(IHL_MIN, cfg_wanted_port, 0, 0);
        send_bytes(0, frame_buf.size());
        wait_for_drain();

        // Random phases with different idling and configuration.
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    write_reg(CFG_WANTED_PORT, 16'h0000);
                    write_reg(CFG_PAYLOAD_CAP, 16'hFFFF);
                end
                1:
                begin
                    send_idle_pct  = 80;
                    recv_stall_pct = 0;
                    write_reg(CFG_WANTED_PORT, 16'($urandom));
                    write_reg(CFG_PAYLOAD_CAP, 16'($urandom_range(64, 8)));
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 80;
                    write_reg(CFG_WANTED_PORT, 16'hFFFF);
                    write_reg(CFG_PAYLOAD_CAP, PAYLOAD_CAP_RESET);
                end
                default:
                begin
                    send_idle_pct  = 35;
                    recv_stall_pct = 35;
                    write_reg(CFG_WANTED_PORT, 16'($urandom));
                    write_reg(CFG_PAYLOAD_CAP, 16'($urandom_range(16)));
                end
            endcase
            random_traffic(PHASE_BYTES);
            wait_for_drain();
        end

        // Allow any stray result to show up before the verdict.
        repeat (8) @(negedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
